[design/lowest_common_ancestor_lifting_unit_assert.svh]
// ----------------------------------------------------------------------------
// lca lifting unit assertion macros
// shared property macros for the controller and datapath checks
// ----------------------------------------------------------------------------
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_UNIT_ASSERT_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_UNIT_ASSERT_SVH

// same-cycle implication
`define LCAL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lca lifting unit check failed");

// next-cycle implication
`define LCAL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lca lifting unit check failed");

`endif

[design/lcal_pkg.sv]
// ----------------------------------------------------------------------------
// lcal_pkg
// shared widths, codes and types of the lca lifting unit
// ----------------------------------------------------------------------------
package lcal_pkg;

   localparam int NODE_W         = 10;
   localparam int DEP_W          = 10;
   localparam int COUNT_W        = 11;
   localparam int ACT_W          = 2;
   localparam int REQ_DATA_W     = 32;
   localparam int RSP_DATA_W     = 16;
   localparam int DEF_MAX_NODES  = 1024;
   localparam int DEF_MAX_LEVELS = 10;

   localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_B_RD,
      S_B_MID,
      S_B_WR,
      S_Q_DB,
      S_Q_SWAP,
      S_L1_RD,
      S_L1_UPD,
      S_CHK,
      S_L2_RD,
      S_L2_UPD,
      S_PAR_RD,
      S_DONE_P,
      S_DONE_PAR
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_BUILD_START,
      OP_QUERY_START,
      OP_B_RD,
      OP_B_MID,
      OP_B_WR,
      OP_Q_DB,
      OP_Q_SWAP,
      OP_L1_RD,
      OP_L1_UPD,
      OP_L2_RD,
      OP_L2_UPD,
      OP_PAR_RD,
      OP_RESP_P,
      OP_RESP_PAR
   } op_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] node;
   } entry_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic lvl_zero;
      logic build_last;
      logic p_eq_q;
      logic bad;
      logic out_free;
   } status_type;

endpackage

[design/lcal_ctrl.sv]
// ----------------------------------------------------------------------------
// lcal_ctrl
// sequencer for load, table build and query of the lca lifting unit
// ----------------------------------------------------------------------------
`include "lowest_common_ancestor_lifting_unit_assert.svh"

module lcal_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [lcal_pkg::ACT_W-1:0]  req_action,
   input  lcal_pkg::status_type        status,
   output lcal_pkg::cmd_type           cmd
);

   lcal_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcal_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcal_pkg::S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_action)
                  lcal_pkg::ACT_BUILD: state_in = lcal_pkg::S_B_RD;
                  lcal_pkg::ACT_QUERY: state_in = lcal_pkg::S_Q_DB;
                  default:             state_in = lcal_pkg::S_IDLE;
               endcase
            end
         end
         lcal_pkg::S_B_RD:
            state_in = status.lvl_zero ? lcal_pkg::S_B_WR : lcal_pkg::S_B_MID;
         lcal_pkg::S_B_MID: state_in = lcal_pkg::S_B_WR;
         lcal_pkg::S_B_WR:
            state_in = status.build_last ? lcal_pkg::S_IDLE : lcal_pkg::S_B_RD;
         lcal_pkg::S_Q_DB: state_in = lcal_pkg::S_Q_SWAP;
         lcal_pkg::S_Q_SWAP:
            state_in = status.bad ? lcal_pkg::S_DONE_P : lcal_pkg::S_L1_RD;
         lcal_pkg::S_L1_RD: state_in = lcal_pkg::S_L1_UPD;
         lcal_pkg::S_L1_UPD:
            state_in = status.lvl_zero ? lcal_pkg::S_CHK : lcal_pkg::S_L1_RD;
         lcal_pkg::S_CHK:
            state_in = status.p_eq_q ? lcal_pkg::S_DONE_P : lcal_pkg::S_L2_RD;
         lcal_pkg::S_L2_RD: state_in = lcal_pkg::S_L2_UPD;
         lcal_pkg::S_L2_UPD:
            state_in = status.lvl_zero ? lcal_pkg::S_PAR_RD : lcal_pkg::S_L2_RD;
         lcal_pkg::S_PAR_RD: state_in = lcal_pkg::S_DONE_PAR;
         lcal_pkg::S_DONE_P, lcal_pkg::S_DONE_PAR:
            state_in = status.out_free ? lcal_pkg::S_IDLE : state_ff;
         default: state_in = lcal_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = lcal_pkg::OP_NONE;
      unique case (state_ff)
         lcal_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_action)
                  lcal_pkg::ACT_LOAD:  cmd.op = lcal_pkg::OP_LOAD;
                  lcal_pkg::ACT_BUILD: cmd.op = lcal_pkg::OP_BUILD_START;
                  lcal_pkg::ACT_QUERY: cmd.op = lcal_pkg::OP_QUERY_START;
                  default:             cmd.op = lcal_pkg::OP_NONE;
               endcase
            end
         end
         lcal_pkg::S_B_RD:   cmd.op = lcal_pkg::OP_B_RD;
         lcal_pkg::S_B_MID:  cmd.op = lcal_pkg::OP_B_MID;
         lcal_pkg::S_B_WR:   cmd.op = lcal_pkg::OP_B_WR;
         lcal_pkg::S_Q_DB:   cmd.op = lcal_pkg::OP_Q_DB;
         lcal_pkg::S_Q_SWAP: cmd.op = lcal_pkg::OP_Q_SWAP;
         lcal_pkg::S_L1_RD:  cmd.op = lcal_pkg::OP_L1_RD;
         lcal_pkg::S_L1_UPD: cmd.op = lcal_pkg::OP_L1_UPD;
         lcal_pkg::S_CHK:    cmd.op = lcal_pkg::OP_NONE;
         lcal_pkg::S_L2_RD:  cmd.op = lcal_pkg::OP_L2_RD;
         lcal_pkg::S_L2_UPD: cmd.op = lcal_pkg::OP_L2_UPD;
         lcal_pkg::S_PAR_RD: cmd.op = lcal_pkg::OP_PAR_RD;
         lcal_pkg::S_DONE_P:
            cmd.op = status.out_free ? lcal_pkg::OP_RESP_P : lcal_pkg::OP_NONE;
         lcal_pkg::S_DONE_PAR:
            cmd.op = status.out_free ? lcal_pkg::OP_RESP_PAR : lcal_pkg::OP_NONE;
         default: cmd.op = lcal_pkg::OP_NONE;
      endcase
   end

   `LCAL_ASSERT_NEXT(a_query_starts, req_tvalid && req_tready && req_action == lcal_pkg::ACT_QUERY, state_ff == lcal_pkg::S_Q_DB)
   `LCAL_ASSERT_NEXT(a_done_frees, (state_ff == lcal_pkg::S_DONE_P || state_ff == lcal_pkg::S_DONE_PAR) && status.out_free, state_ff == lcal_pkg::S_IDLE)
   `LCAL_ASSERT_NEXT(a_lift_to_check, state_ff == lcal_pkg::S_L1_UPD && status.lvl_zero, state_ff == lcal_pkg::S_CHK)

endmodule

[design/lcal_dp.sv]
// ----------------------------------------------------------------------------
// lcal_dp
// node stores, ancestor table and lifting registers of the lca lifting unit
// ----------------------------------------------------------------------------
`include "lowest_common_ancestor_lifting_unit_assert.svh"

module lcal_dp #(
   parameter int MAX_NODES  = lcal_pkg::DEF_MAX_NODES,
   parameter int MAX_LEVELS = lcal_pkg::DEF_MAX_LEVELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lcal_pkg::cmd_type             cmd,
   output lcal_pkg::status_type          status,
   input  logic [lcal_pkg::NODE_W-1:0]   req_node_a,
   input  logic [lcal_pkg::NODE_W-1:0]   req_node_b,
   input  logic [lcal_pkg::DEP_W-1:0]    req_node_depth,
   input  logic                          csr_valid,
   input  logic [lcal_pkg::COUNT_W-1:0]  csr_wdata,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [lcal_pkg::NODE_W-1:0]   rsp_ancestor,
   output logic                          rsp_bad_node
);

   localparam int AW     = $clog2(MAX_NODES);
   localparam int LW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int CMP_W  = (CNT_W > lcal_pkg::COUNT_W) ? CNT_W : lcal_pkg::COUNT_W;
   localparam int MW     = (CNT_W > lcal_pkg::NODE_W) ? CNT_W : lcal_pkg::NODE_W;
   localparam int SPAN_W = ((MAX_LEVELS > CNT_W) ? MAX_LEVELS : CNT_W) + 1;
   localparam int LIFT_W = ((MAX_LEVELS > lcal_pkg::DEP_W) ? MAX_LEVELS : lcal_pkg::DEP_W) + 1;

   logic [lcal_pkg::NODE_W-1:0] par_mem [MAX_NODES];
   logic [lcal_pkg::DEP_W-1:0]  dep_mem [MAX_NODES];
   lcal_pkg::entry_type         tab_mem [MAX_LEVELS][MAX_NODES];

   logic [lcal_pkg::NODE_W-1:0] par_rd_ff;
   logic [lcal_pkg::DEP_W-1:0]  dep_rd_ff;
   lcal_pkg::entry_type         tab_rd0_ff, tab_rd1_ff;

   logic [lcal_pkg::COUNT_W-1:0] count_ff;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [AW-1:0]                row_ff, row_in;
   logic [LW-1:0]                lvl_ff, lvl_in;
   logic [lcal_pkg::NODE_W-1:0]  a_ff, a_in, b_ff, b_in, p_ff, p_in, q_ff, q_in;
   logic [lcal_pkg::DEP_W-1:0]   da_ff, da_in, dq_ff, dq_in;
   logic                         bad_ff, bad_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lcal_pkg::NODE_W-1:0]  anc_ff, anc_in;
   logic                         rbad_ff, rbad_in;

   logic                         par_we, par_re, dep_re, tab_we, tab_re0, tab_re1;
   logic [AW-1:0]                par_addr, dep_addr, tab_addr0, tab_addr1, load_addr;
   logic [LW-1:0]                tab_lvl0, tab_lvl1;
   lcal_pkg::entry_type          tab_wdata;

   logic [CNT_W-1:0] limit;
   logic [LW-1:0]    lvl_prev, lvl_dec;
   logic             lvl_zero, last_row, row_act, par_ok, span_ok, mid_ok, lift_ok;
   logic             out_free;

   assign limit    = (CMP_W'(count_ff) > CMP_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                            : CNT_W'(count_ff);
   assign lvl_zero = (lvl_ff == '0);
   assign lvl_prev = lvl_ff - LW'(1);
   assign lvl_dec  = lvl_zero ? LW'(MAX_LEVELS - 1) : lvl_prev;
   assign last_row = (row_ff == AW'(MAX_NODES - 1));
   assign row_act  = (CNT_W'(row_ff) < n_ff);
   assign par_ok   = (MW'(par_rd_ff) < MW'(MAX_NODES));
   assign span_ok  = ((SPAN_W'(1) << lvl_ff) < SPAN_W'(n_ff));
   assign mid_ok   = tab_rd0_ff.valid && (MW'(tab_rd0_ff.node) < MW'(n_ff));
   assign lift_ok  = tab_rd0_ff.valid && (LIFT_W'(dep_rd_ff) >=
                     LIFT_W'(dq_ff) + (LIFT_W'(1) << lvl_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_addr = AW'(req_node_a);

   always_comb begin
      n_in         = n_ff;
      row_in       = row_ff;
      lvl_in       = lvl_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      da_in        = da_ff;
      dq_in        = dq_ff;
      bad_in       = bad_ff;
      anc_in       = anc_ff;
      rbad_in      = rbad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      par_we       = 1'b0;
      par_re       = 1'b0;
      dep_re       = 1'b0;
      tab_we       = 1'b0;
      tab_re0      = 1'b0;
      tab_re1      = 1'b0;
      par_addr     = row_ff;
      dep_addr     = AW'(p_ff);
      tab_addr0    = AW'(p_ff);
      tab_addr1    = AW'(q_ff);
      tab_lvl0     = lvl_ff;
      tab_lvl1     = lvl_ff;
      tab_wdata    = '0;
      unique case (cmd.op)
         lcal_pkg::OP_LOAD: begin
            par_we = (MW'(req_node_a) < MW'(MAX_NODES));
         end
         lcal_pkg::OP_BUILD_START: begin
            n_in   = limit;
            row_in = '0;
            lvl_in = '0;
         end
         lcal_pkg::OP_QUERY_START: begin
            n_in     = limit;
            a_in     = req_node_a;
            b_in     = req_node_b;
            bad_in   = (MW'(req_node_a) >= MW'(limit)) || (MW'(req_node_b) >= MW'(limit));
            dep_re   = 1'b1;
            dep_addr = AW'(req_node_a);
         end
         lcal_pkg::OP_B_RD: begin
            par_re    = lvl_zero;
            tab_re0   = !lvl_zero;
            tab_lvl0  = lvl_prev;
            tab_addr0 = row_ff;
         end
         lcal_pkg::OP_B_MID: begin
            tab_re1   = 1'b1;
            tab_lvl1  = lvl_prev;
            tab_addr1 = AW'(tab_rd0_ff.node);
         end
         lcal_pkg::OP_B_WR: begin
            tab_we = 1'b1;
            if (lvl_zero) begin
               tab_wdata.valid = row_act && par_ok;
               tab_wdata.node  = par_rd_ff;
            end else if (row_act && span_ok && mid_ok) begin
               tab_wdata = tab_rd1_ff;
            end
            if (last_row) begin
               row_in = '0;
               lvl_in = lvl_ff + LW'(1);
            end else begin
               row_in = row_ff + AW'(1);
            end
         end
         lcal_pkg::OP_Q_DB: begin
            da_in    = dep_rd_ff;
            dep_re   = 1'b1;
            dep_addr = AW'(b_ff);
         end
         lcal_pkg::OP_Q_SWAP: begin
            lvl_in = LW'(MAX_LEVELS - 1);
            if (da_ff < dep_rd_ff) begin
               p_in  = b_ff;
               q_in  = a_ff;
               dq_in = da_ff;
            end else begin
               p_in  = a_ff;
               q_in  = b_ff;
               dq_in = dep_rd_ff;
            end
         end
         lcal_pkg::OP_L1_RD: begin
            tab_re0 = 1'b1;
            dep_re  = 1'b1;
         end
         lcal_pkg::OP_L1_UPD: begin
            if (lift_ok) begin
               p_in = tab_rd0_ff.node;
            end
            lvl_in = lvl_dec;
         end
         lcal_pkg::OP_L2_RD: begin
            tab_re0 = 1'b1;
            tab_re1 = 1'b1;
         end
         lcal_pkg::OP_L2_UPD: begin
            if (tab_rd0_ff.valid && tab_rd1_ff.valid && tab_rd0_ff.node != tab_rd1_ff.node) begin
               p_in = tab_rd0_ff.node;
               q_in = tab_rd1_ff.node;
            end
            lvl_in = lvl_dec;
         end
         lcal_pkg::OP_PAR_RD: begin
            par_re   = 1'b1;
            par_addr = AW'(p_ff);
         end
         lcal_pkg::OP_RESP_P: begin
            rsp_valid_in = 1'b1;
            anc_in       = bad_ff ? '0 : p_ff;
            rbad_in      = bad_ff;
         end
         lcal_pkg::OP_RESP_PAR: begin
            rsp_valid_in = 1'b1;
            anc_in       = par_rd_ff;
            rbad_in      = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[load_addr] <= req_node_b;
         dep_mem[load_addr] <= req_node_depth;
      end
      if (par_re) begin
         par_rd_ff <= par_mem[par_addr];
      end
      if (dep_re) begin
         dep_rd_ff <= dep_mem[dep_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[lvl_ff][row_ff] <= tab_wdata;
      end
      if (tab_re0) begin
         tab_rd0_ff <= tab_mem[tab_lvl0][tab_addr0];
      end
      if (tab_re1) begin
         tab_rd1_ff <= tab_mem[tab_lvl1][tab_addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= lcal_pkg::COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      row_ff  <= row_in;
      lvl_ff  <= lvl_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      da_ff   <= da_in;
      dq_ff   <= dq_in;
      bad_ff  <= bad_in;
      anc_ff  <= anc_in;
      rbad_ff <= rbad_in;
   end

   assign status.lvl_zero   = lvl_zero;
   assign status.build_last = last_row && (lvl_ff == LW'(MAX_LEVELS - 1));
   assign status.p_eq_q     = (p_ff == q_ff);
   assign status.bad        = bad_ff;
   assign status.out_free   = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = anc_ff;
   assign rsp_bad_node = rbad_ff;

   `LCAL_ASSERT_NOW(a_bad_gives_zero, rsp_valid_ff && rbad_ff, anc_ff == '0)
   `LCAL_ASSERT_NEXT(a_lift_moves, cmd.op == lcal_pkg::OP_L1_UPD && lift_ok, p_ff == $past(tab_rd0_ff.node))
   `LCAL_ASSERT_NEXT(a_rsp_held, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable({anc_ff, rbad_ff}))

endmodule

[design/lowest_common_ancestor_lifting_unit.sv]
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_unit
// binary lifting lca engine: node loads, ancestor table build, queries
// ----------------------------------------------------------------------------
// load: from idle; build: read, write at level 0, read, mid, write higher up, all rows
// query: depth reads, swap, lift loop, meet check, then second loop and parent read
// query time is set by the registered table reads, a read and an update state per level
// result sits in an output register; next item is taken while it waits
// reset clears control and sets node_count to 1; stores and table are not cleared
module lowest_common_ancestor_lifting_unit #(
   parameter int MAX_NODES  = lcal_pkg::DEF_MAX_NODES,
   parameter int MAX_LEVELS = lcal_pkg::DEF_MAX_LEVELS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lcal_pkg::REQ_DATA_W-1:0]  req_tdata,  // node_a, node_b, node_depth
   input  logic [lcal_pkg::ACT_W-1:0]       req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lcal_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // ancestor
   output logic [0:0]                       rsp_tuser,  // bad_node
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lcal_pkg::COUNT_W-1:0]     csr_wdata   // node_count
);

   lcal_pkg::cmd_type           cmd;
   lcal_pkg::status_type        status;
   logic [lcal_pkg::NODE_W-1:0] ancestor;
   logic                        bad_node;

   assign csr_ready = 1'b1;

   lcal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   lcal_dp #(
      .MAX_NODES  (MAX_NODES),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_node_a     (req_tdata[lcal_pkg::NODE_W-1:0]),
      .req_node_b     (req_tdata[2*lcal_pkg::NODE_W-1:lcal_pkg::NODE_W]),
      .req_node_depth (req_tdata[2*lcal_pkg::NODE_W+lcal_pkg::DEP_W-1:2*lcal_pkg::NODE_W]),
      .csr_valid      (csr_valid),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_ancestor   (ancestor),
      .rsp_bad_node   (bad_node)
   );

   assign rsp_tdata = {{(lcal_pkg::RSP_DATA_W - lcal_pkg::NODE_W){1'b0}}, ancestor};
   assign rsp_tuser = bad_node;

endmodule
